// ===== design/kda_pkg.sv =====
// kda_pkg: shared types and constants for the key debounce / autorepeat block
// register indexes, reset values, configuration and result beat structs
// no dependencies
package kda_pkg;

   localparam int CODE_W  = 7;
   localparam int COUNT_W = 16;
   localparam int INDEX_W = 2;

   localparam logic [INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_DELAY    = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_REPEAT   = 2'd2;

   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [COUNT_W-1:0] DELAY_RESET    = 16'd500;
   localparam logic [COUNT_W-1:0] REPEAT_RESET   = 16'd100;

   typedef struct packed {
      logic [COUNT_W-1:0] debounce_ticks;
      logic [COUNT_W-1:0] delay_ticks;
      logic [COUNT_W-1:0] repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] key_code;
      logic              is_repeat;
      logic              last_of_tick;
   } result_type;

endpackage

// ===== design/kda_core.sv =====
// kda_core: held code and debounce, delay and repeat counters
// turns one registered tick into zero, one or two result beats; uses kda_pkg
module kda_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [kda_pkg::CODE_W-1:0] pin_levels,
   input  kda_pkg::cfg_type           cfg,
   output logic [1:0]                 push_n,
   output kda_pkg::result_type        first_result,
   output kda_pkg::result_type        second_result
);
   import kda_pkg::*;

   logic [CODE_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] stable_ff, stable_in;
   logic [COUNT_W-1:0] delay_ff, delay_in;
   logic [COUNT_W-1:0] repeat_ff, repeat_in;
   logic [CODE_W-1:0]  code;
   logic               emit_first;
   logic               emit_repeat;

   assign code = ~pin_levels;

   always_comb begin
      emit_first  = 1'b0;
      emit_repeat = 1'b0;
      if (code == held_ff) begin
         held_in   = held_ff;
         stable_in = (stable_ff != '0) ? stable_ff - 1'b1 : stable_ff;
         delay_in  = delay_ff;
         repeat_in = repeat_ff;
      end else begin
         held_in   = code;
         stable_in = cfg.debounce_ticks;
         delay_in  = cfg.delay_ticks;
         repeat_in = cfg.repeat_ticks;
      end
      if (stable_in == '0 && held_in != '0) begin
         emit_first = (delay_in == cfg.delay_ticks);
         if (delay_in != '0) begin
            delay_in = delay_in - 1'b1;
         end else if (repeat_in != '0) begin
            repeat_in = repeat_in - 1'b1;
         end else begin
            emit_repeat = 1'b1;
            repeat_in   = cfg.repeat_ticks;
         end
      end
   end

   assign push_n = fire ? ({1'b0, emit_first} + {1'b0, emit_repeat}) : 2'd0;

   always_comb begin
      first_result.key_code      = held_in;
      first_result.is_repeat     = ~emit_first;
      first_result.last_of_tick  = ~(emit_first & emit_repeat);
      second_result.key_code     = held_in;
      second_result.is_repeat    = 1'b1;
      second_result.last_of_tick = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         stable_ff <= DEBOUNCE_RESET;
         delay_ff  <= '0;
         repeat_ff <= '0;
      end else if (fire) begin
         held_ff   <= held_in;
         stable_ff <= stable_in;
         delay_ff  <= delay_in;
         repeat_ff <= repeat_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_two_needs_zero_delay: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd2 |-> cfg.delay_ticks == '0)
      else $error("two beats in one tick with nonzero delay");
`endif

endmodule

// ===== design/kda_fifo.sv =====
// kda_fifo: four-entry result queue, up to two pushes and one pop per cycle
// decouples the tick path from the result channel; uses kda_pkg
module kda_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_n,
   input  kda_pkg::result_type first_result,
   input  kda_pkg::result_type second_result,
   input  logic                pop,
   output kda_pkg::result_type head,
   output logic                not_empty,
   output logic [2:0]          count
);
   import kda_pkg::*;

   result_type entry_ff [4];
   logic [1:0] wp_ff, wp_in;
   logic [1:0] rp_ff, rp_in;
   logic [2:0] count_ff, count_in;
   logic       do_pop;

   assign not_empty = (count_ff != 3'd0);
   assign do_pop    = pop & not_empty;
   assign head      = entry_ff[rp_ff];
   assign count     = count_ff;

   assign wp_in    = wp_ff + push_n;
   assign rp_in    = rp_ff + {1'b0, do_pop};
   assign count_in = count_ff + {1'b0, push_n} - {2'b00, do_pop};

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wp_ff] <= first_result;
      end
      if (push_n == 2'd2) begin
         entry_ff[wp_ff + 2'd1] <= second_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> count_ff <= 3'd2)
      else $error("push into result queue without room for two");
   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      do_pop && push_n == 2'd0 |=> count_ff == $past(count_ff) - 3'd1)
      else $error("result queue count wrong after pop");
`endif

endmodule

// ===== design/key_debounce_autorepeat.sv =====
// key_debounce_autorepeat: keypad debounce with typematic repeat, top level
// csr registers, input register, kda_core tick logic and kda_fifo result queue
// uses kda_pkg
//
// Each req beat is one tick of seven active-low pin levels. The beat lands in
// an input register; from there, once the result queue has room, the tick
// logic updates the held code and its stable, delay and repeat counters and
// pushes zero, one or two rsp beats into a four-entry result queue. A new
// tick can enter every cycle; the stage moves on only while the queue has
// room for two beats, so the sustained rate is set by how fast rsp beats are
// taken (one per cycle at most, two only on a tick with zero delay). A req
// beat reaches rsp through the input register and the result queue. The
// csr port is always ready; index 0 debounce_ticks, 1 delay_ticks,
// 2 repeat_ticks, 3 is ignored. Writes are meant for idle periods only.
module key_debounce_autorepeat (
   input  logic                        clock,
   input  logic                        reset,
   // tick channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [kda_pkg::CODE_W-1:0]  req_pin_levels,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [kda_pkg::CODE_W-1:0]  rsp_key_code,
   output logic                        rsp_is_repeat,
   output logic                        rsp_last_of_tick,
   // register write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [kda_pkg::INDEX_W-1:0] csr_index,
   input  logic [kda_pkg::COUNT_W-1:0] csr_wdata
);
   import kda_pkg::*;

   cfg_type           cfg_ff;
   logic              in_valid_ff;
   logic [CODE_W-1:0] in_pins_ff;
   logic              process;
   logic [1:0]        push_n;
   logic [2:0]        queue_count;
   result_type        first_result;
   result_type        second_result;
   result_type        head;

   // registers take every write beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.delay_ticks    <= DELAY_RESET;
         cfg_ff.repeat_ticks   <= REPEAT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_ticks <= csr_wdata;
            CSR_DELAY:    cfg_ff.delay_ticks    <= csr_wdata;
            CSR_REPEAT:   cfg_ff.repeat_ticks   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // tick stage runs when the queue can hold the worst case of two beats
   assign process   = in_valid_ff && (queue_count <= 3'd2);
   assign req_ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pins_ff <= req_pin_levels;
      end
   end

   kda_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (process),
      .pin_levels    (in_pins_ff),
      .cfg           (cfg_ff),
      .push_n        (push_n),
      .first_result  (first_result),
      .second_result (second_result)
   );

   kda_fifo u_fifo (
      .clock         (clock),
      .reset         (reset),
      .push_n        (push_n),
      .first_result  (first_result),
      .second_result (second_result),
      .pop           (rsp_ready),
      .head          (head),
      .not_empty     (rsp_valid),
      .count         (queue_count)
   );

   assign rsp_key_code     = head.key_code;
   assign rsp_is_repeat    = head.is_repeat;
   assign rsp_last_of_tick = head.last_of_tick;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |-> !req_ready)
      else $error("tick accepted while stage is stalled");
   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> push_n == 2'd0)
      else $error("result pushed without a tick in the stage");
`endif

endmodule

// ===== tb/tb_key_debounce_autorepeat.sv =====
// tb_key_debounce_autorepeat: self-checking bench for the key debounce / autorepeat block
// directed table then random key presses with bounce, checked beat by beat against
// an in-bench tick model; depends on kda_pkg and key_debounce_autorepeat
module tb_key_debounce_autorepeat;
   timeunit 1ns;
   timeprecision 1ps;

   import kda_pkg::*;

   localparam int     CLK_PERIOD    = 20;
   localparam int     RESET_CYCLES  = 11;
   localparam int     SETTLE_CYCLES = 8;        // tick stage plus result queue, with margin
   localparam int     SEGMENTS      = 9;
   localparam int     SEG_ITEMS     = 145;
   localparam int     PRESSURE_SEG  = 6;        // zero delay, no idling: fastest beat rate
   localparam int     LONG_HOLD     = 300;
   localparam int     PRINT_CAP     = 50;
   localparam int     PREDICTED     = -1;       // row beats taken from the tick model
   localparam longint RUN_LIMIT_NS  = 64'd8_000_000;
   localparam logic [INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CODE_W-1:0]  NO_KEY     = 7'h7F;   // all pins high, nothing pressed

   // directed table: a tick row either names the beats it causes or leaves them to the
   // tick model; one beat means a first emission, two mean first plus repeat of one code
   typedef enum logic {ROW_TICK, ROW_SETUP} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CODE_W-1:0]  pins;
      logic [COUNT_W-1:0] set_debounce;
      logic [COUNT_W-1:0] set_delay;
      logic [COUNT_W-1:0] set_repeat;
      int                 exp_n;
      logic [CODE_W-1:0]  exp_code;
   } row_type;

   typedef struct {
      int                beats;
      logic [CODE_W-1:0] code;
   } row_claim_type;

   row_type directed_rows [28] = '{
      // reset values: debounce 20, so nothing can come out yet
      '{ROW_TICK , NO_KEY, 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , 7'h00 , 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , NO_KEY, 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      // all counts zero: every held tick gives first and repeat beat
      '{ROW_SETUP, NO_KEY, 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , 7'h7E , 16'd0    , 16'd0    , 16'd0    , 2        , 7'h01},
      '{ROW_TICK , 7'h7E , 16'd0    , 16'd0    , 16'd0    , 2        , 7'h01},
      '{ROW_TICK , 7'h00 , 16'd0    , 16'd0    , 16'd0    , 2        , 7'h7F},
      '{ROW_TICK , NO_KEY, 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      // zero debounce, full-scale delay: one first beat, then a long wait
      '{ROW_SETUP, NO_KEY, 16'd0    , 16'd65535, 16'd65535, 0        , 7'h00},
      '{ROW_TICK , 7'h3F , 16'd0    , 16'd0    , 16'd0    , 1        , 7'h40},
      '{ROW_TICK , 7'h3F , 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , NO_KEY, 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      // full-scale debounce: never settles within these ticks
      '{ROW_SETUP, NO_KEY, 16'd65535, 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , 7'h55 , 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , 7'h55 , 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      '{ROW_TICK , NO_KEY, 16'd0    , 16'd0    , 16'd0    , 0        , 7'h00},
      // small counts: a held key runs through debounce, delay and a repeat
      '{ROW_SETUP, NO_KEY, 16'd2    , 16'd3    , 16'd1    , 0        , 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      // one-tick contact bounce restarts the whole sequence
      '{ROW_TICK , 7'h6F , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , 7'h6D , 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00},
      '{ROW_TICK , NO_KEY, 16'd0    , 16'd0    , 16'd0    , PREDICTED, 7'h00}
   };

   // block ports; the inputs are all known from time zero
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [CODE_W-1:0]   req_pin_levels   = NO_KEY;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [CODE_W-1:0]   rsp_key_code;
   logic                rsp_is_repeat;
   logic                rsp_last_of_tick;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index        = CSR_DEBOUNCE;
   logic [COUNT_W-1:0]  csr_wdata        = '0;

   // tick model state, a private copy of the block's registers and counters
   cfg_type             shadow_cfg       = '{DEBOUNCE_RESET, DELAY_RESET, REPEAT_RESET};
   logic [CODE_W-1:0]   held_key         = '0;
   logic [COUNT_W-1:0]  stable_cnt       = DEBOUNCE_RESET;
   logic [COUNT_W-1:0]  delay_cnt        = '0;
   logic [COUNT_W-1:0]  repeat_cnt       = '0;
   result_type          tick_beats [2];

   result_type          key_beats_due [$];  // beats still owed by the block, oldest first
   row_claim_type       typed_rows [$];     // one entry per offered tick, in offer order

   int                  send_idle_pct    = 23;
   int                  recv_idle_pct    = 64;
   logic                hold_request     = 1'b0;
   logic                hold_taken       = 1'b0;
   int                  hold_left        = 0;
   int                  offered          = 0;
   int                  mismatch_count   = 0;
   int                  ticks_seen       = 0;
   int                  first_beats      = 0;
   int                  repeat_beats     = 0;
   int                  csr_writes       = 0;

   key_debounce_autorepeat DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_is_repeat    (rsp_is_repeat),
      .rsp_last_of_tick (rsp_last_of_tick),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // one line per mismatch, quiet after the first few dozen
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // one debounce tick: updates the held code and counters, fills tick_beats,
   // returns how many key beats this tick sends
   function automatic int debounce_tick(input logic [CODE_W-1:0] pins);
      logic [CODE_W-1:0] code;
      int                n;
      code = ~pins;
      n = 0;
      if (code == held_key) begin
         if (stable_cnt != '0)
            stable_cnt--;
      end else begin
         // new code: every counter restarts from the current settings
         stable_cnt = shadow_cfg.debounce_ticks;
         delay_cnt  = shadow_cfg.delay_ticks;
         repeat_cnt = shadow_cfg.repeat_ticks;
         held_key   = code;
      end
      if (stable_cnt == '0 && held_key != '0) begin
         // first emission while the delay count is still untouched
         if (delay_cnt == shadow_cfg.delay_ticks) begin
            tick_beats[n] = '{held_key, 1'b0, 1'b0};
            n++;
         end
         if (delay_cnt != '0)
            delay_cnt--;
         else if (repeat_cnt != '0)
            repeat_cnt--;
         else begin
            // repeat period ran out: send again and restart the period
            tick_beats[n] = '{held_key, 1'b1, 1'b0};
            n++;
            repeat_cnt = shadow_cfg.repeat_ticks;
         end
      end
      if (n > 0)
         tick_beats[n-1].last_of_tick = 1'b1;
      return n;
   endfunction

   // watches all three channels at each edge; result beats are checked before the
   // tick accepted on the same edge is modeled, as its beats pass the input register and queue first
   always @(posedge clock) begin : watch
      result_type    want;
      row_claim_type claim;
      int            n;
      if (reset) begin
         shadow_cfg = '{DEBOUNCE_RESET, DELAY_RESET, REPEAT_RESET};
         held_key   = '0;
         stable_cnt = DEBOUNCE_RESET;
         delay_cnt  = '0;
         repeat_cnt = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (key_beats_due.size() == 0)
               report_mismatch($sformatf("unexpected beat code %h repeat %b last %b",
                                         rsp_key_code, rsp_is_repeat, rsp_last_of_tick));
            else begin
               want = key_beats_due.pop_front();
               if (rsp_key_code !== want.key_code)
                  report_mismatch($sformatf("key_code %h, want %h",
                                            rsp_key_code, want.key_code));
               if (rsp_is_repeat !== want.is_repeat)
                  report_mismatch($sformatf("is_repeat %b, want %b (code %h)",
                                            rsp_is_repeat, want.is_repeat, want.key_code));
               if (rsp_last_of_tick !== want.last_of_tick)
                  report_mismatch($sformatf("last_of_tick %b, want %b (code %h)",
                                            rsp_last_of_tick, want.last_of_tick,
                                            want.key_code));
            end
            if (rsp_is_repeat)
               repeat_beats++;
            else
               first_beats++;
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_DEBOUNCE: shadow_cfg.debounce_ticks = csr_wdata;
               CSR_DELAY:    shadow_cfg.delay_ticks    = csr_wdata;
               CSR_REPEAT:   shadow_cfg.repeat_ticks   = csr_wdata;
               default: ;    // unused index, ignored by the block
            endcase
         end
         if (req_valid && req_ready) begin
            ticks_seen++;
            n = debounce_tick(req_pin_levels);
            claim = '{PREDICTED, '0};
            if (typed_rows.size() != 0)
               claim = typed_rows.pop_front();
            if (claim.beats == PREDICTED) begin
               for (int i = 0; i < n; i++)
                  key_beats_due.push_back(tick_beats[i]);
            end else if (claim.beats == 2) begin
               key_beats_due.push_back('{claim.code, 1'b0, 1'b0});
               key_beats_due.push_back('{claim.code, 1'b1, 1'b1});
            end else if (claim.beats == 1)
               key_beats_due.push_back('{claim.code, 1'b0, 1'b1});
         end
      end
   end

   // result side: random stalls, plus one long hold-off when asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // offer one tick, after a random gap; returns on the edge where it is taken
   task automatic send_tick(input logic [CODE_W-1:0] pins, input int exp_n = PREDICTED,
                            input logic [CODE_W-1:0] exp_code = '0);
      typed_rows.push_back('{exp_n, exp_code});
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pin_levels <= pins;
      offered++;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // drop valid, let every owed beat come out, then give the pipeline time to empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (key_beats_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [INDEX_W-1:0] idx, input logic [COUNT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // all three registers back to back, plus a write to the unused index
   task automatic configure(input logic [COUNT_W-1:0] db, input logic [COUNT_W-1:0] dl,
                            input logic [COUNT_W-1:0] rp);
      write_csr(CSR_DEBOUNCE, db);
      write_csr(CSR_DELAY, dl);
      write_csr(CSR_REPEAT, rp);
      write_csr(CSR_UNUSED, COUNT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] db;
      logic [COUNT_W-1:0] dl;
      logic [COUNT_W-1:0] rp;
      logic [CODE_W-1:0]  code;
      int                 hold;
      int                 bounce_at;
      int                 target;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, sender and receiver both stalling
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SETUP) begin
            wait_idle();
            configure(directed_rows[r].set_debounce, directed_rows[r].set_delay,
                      directed_rows[r].set_repeat);
         end else
            send_tick(directed_rows[r].pins, directed_rows[r].exp_n,
                      directed_rows[r].exp_code);
      end

      // random part: three idling mixes, three register settings in each
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 3)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct <= 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct <= 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         // a key may still be held here, so counters carry across the new settings
         wait_idle();
         db = COUNT_W'($urandom_range(0, 4));
         dl = COUNT_W'($urandom_range(0, 8));
         rp = COUNT_W'($urandom_range(0, 4));
         if (seg == PRESSURE_SEG) begin
            // one or two beats per stable tick and a stalled receiver: the queue fills up
            dl = '0;
            hold_request <= 1'b1;
         end
         configure(db, dl, rp);
         target = offered + SEG_ITEMS;
         while (offered < target) begin
            if ($urandom_range(99) < 80) begin
               // a press of random length, often long enough for debounce, delay and repeats
               if ($urandom_range(3) == 0)
                  code = CODE_W'(1 << $urandom_range(CODE_W - 1));
               else
                  code = CODE_W'($urandom_range(1, 127));
               hold = $urandom_range(1, int'(db) + int'(dl) + 3 * int'(rp) + 6);
               bounce_at = ($urandom_range(3) == 0) ? $urandom_range(0, hold - 1) : -1;
               for (int i = 0; i < hold; i++) begin
                  if (i == bounce_at)
                     send_tick(~(code ^ CODE_W'($urandom_range(1, 127))));
                  send_tick(~code);
               end
               repeat ($urandom_range(0, 3)) send_tick(NO_KEY);
            end else begin
               // raw pin noise
               repeat ($urandom_range(1, 4)) send_tick(CODE_W'($urandom));
            end
         end
      end

      wait_idle();
      $display("covered %0d ticks, %0d first and %0d repeat key beats, %0d register writes",
               ticks_seen, first_beats, repeat_beats, csr_writes);
      $display("with zero and full-scale counts, three idling mixes and a %0d-cycle hold-off",
               LONG_HOLD);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d beats still owed", key_beats_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
